/* sv/hcp_pkg.sv */
// ----------------------------------------------------------------------------
// hcp_pkg
// Shared types and constants for the histogram cumulative percentile core.
// ----------------------------------------------------------------------------
package hcp_pkg;

   localparam int NUM_BINS = 256;
   localparam int BIN_W    = $clog2(NUM_BINS);
   localparam int COUNT_W  = 32;
   localparam int PCT_W    = 8;
   localparam int ACTION_W = 2;
   localparam int SHIFT_W  = 4;

   localparam logic [COUNT_W-1:0] STEP_LIMIT  = 32'h00ff_ffff;
   localparam logic [SHIFT_W-1:0] START_SHIFT = 4'd8;
   localparam logic [BIN_W-1:0]   LAST_P      = 8'd255;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD    = 2'd0,
      ACT_COMPUTE = 2'd1,
      ACT_QUERY   = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QUERY,
      ST_CUM_RD,
      ST_CUM_WR,
      ST_SHIFT,
      ST_WALK_RD,
      ST_WALK_EV,
      ST_DONE
   } state_type;

endpackage

/* sv/hcp_ram.sv */
// ----------------------------------------------------------------------------
// hcp_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hcp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/histogram_cumulative_percentile_core.sv */
// ----------------------------------------------------------------------------
// histogram_cumulative_percentile_core
// Raw histogram store with cumulative and inverse-cumulative table build.
// ----------------------------------------------------------------------------
// A load request writes one raw bin. A query request reads both tables;
// the read data is registered into the response in ST_QUERY, and the core
// stays busy until the response register is free to take it.
// A compute request runs a sequencer: the running sum (read and accumulate
// per bin in ST_CUM_RD and ST_CUM_WR), the step normalize in ST_SHIFT, then
// the percentile walk, where each pointer advance passes through ST_WALK_RD
// and ST_WALK_EV and each table entry is written in ST_WALK_EV, limited by
// the registered read of the cumulative RAM. The core takes no new request
// until the current one has finished and its response is registered. All
// 256 bins must be loaded before the first compute.
// ----------------------------------------------------------------------------
module histogram_cumulative_percentile_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [hcp_pkg::ACTION_W-1:0] req_action,
   input  logic [hcp_pkg::BIN_W-1:0]    req_bin_index,
   input  logic [hcp_pkg::COUNT_W-1:0]  req_bin_count,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [hcp_pkg::PCT_W-1:0]    rsp_percentile_value,
   output logic [hcp_pkg::COUNT_W-1:0]  rsp_cumulative_count,
   output logic                         rsp_compute_done
);
   import hcp_pkg::*;

   state_type          state_ff, state_in;
   logic [BIN_W-1:0]   idx_ff, idx_in;     // bin k during sum, pointer p in walk
   logic [BIN_W-1:0]   x_ff, x_in;
   logic [COUNT_W-1:0] acc_ff, acc_in;
   logic [COUNT_W-1:0] step_ff, step_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic [COUNT_W-1:0] run_ff, run_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PCT_W-1:0]   rsp_pct_ff, rsp_pct_in;
   logic [COUNT_W-1:0] rsp_cum_ff, rsp_cum_in;
   logic               rsp_done_ff, rsp_done_in;

   action_type         action;
   logic               req_fire;
   logic               rsp_free;
   logic               shift_more;
   logic               advance_p;
   logic [COUNT_W-1:0] cum_sum;
   logic [COUNT_W-1:0] shifted;

   logic               raw_wr_en, cum_wr_en, pct_wr_en;
   logic [BIN_W-1:0]   cum_rd_addr, pct_rd_addr;
   logic [COUNT_W-1:0] raw_rdata, cum_rdata;
   logic [PCT_W-1:0]   pct_rdata;

   assign action     = action_type'(req_action);
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_fire   = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign cum_sum    = acc_ff + raw_rdata;
   assign shift_more = (step_ff > STEP_LIMIT) && (shift_ff != '0);
   assign shifted    = cum_rdata << shift_ff;
   assign advance_p  = (idx_ff != LAST_P) && (shifted <= run_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (action == ACT_COMPUTE) begin
                  state_in = ST_CUM_RD;
               end else if (action == ACT_QUERY) begin
                  state_in = ST_QUERY;
               end
            end
         end
         ST_QUERY: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         ST_CUM_RD: state_in = ST_CUM_WR;
         ST_CUM_WR: begin
            state_in = (idx_ff == LAST_P) ? ST_SHIFT : ST_CUM_RD;
         end
         ST_SHIFT: begin
            if (!shift_more) state_in = ST_WALK_RD;
         end
         ST_WALK_RD: state_in = ST_WALK_EV;
         ST_WALK_EV: begin
            if (advance_p) begin
               state_in = ST_WALK_RD;
            end else if (x_ff == LAST_P) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // RAM controls
   always_comb begin
      raw_wr_en   = (state_ff == ST_IDLE) && req_fire && (action == ACT_LOAD);
      cum_wr_en   = (state_ff == ST_CUM_WR);
      pct_wr_en   = (state_ff == ST_WALK_EV);
      cum_rd_addr = (state_ff == ST_IDLE) ? req_bin_index : idx_ff;
      pct_rd_addr = (state_ff == ST_IDLE) ? req_bin_index : idx_ff;
   end

   // datapath next values
   always_comb begin
      idx_in   = idx_ff;
      x_in     = x_ff;
      acc_in   = acc_ff;
      step_in  = step_ff;
      shift_in = shift_ff;
      run_in   = run_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               idx_in = (action == ACT_QUERY) ? req_bin_index : '0;
               acc_in = '0;
            end
         end
         ST_CUM_WR: begin
            acc_in   = cum_sum;
            idx_in   = idx_ff + 1'b1;
            step_in  = cum_sum;
            shift_in = START_SHIFT;
         end
         ST_SHIFT: begin
            if (shift_more) begin
               step_in  = step_ff >> 1;
               shift_in = shift_ff - 1'b1;
            end else begin
               run_in = '0;
               x_in   = '0;
            end
         end
         ST_WALK_EV: begin
            if (advance_p) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               x_in   = x_ff + 1'b1;
               run_in = run_ff + step_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pct_in   = rsp_pct_ff;
      rsp_cum_in   = rsp_cum_ff;
      rsp_done_in  = rsp_done_ff;
      if ((state_ff == ST_QUERY) && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_pct_in   = pct_rdata;
         rsp_cum_in   = cum_rdata;
         rsp_done_in  = 1'b0;
      end else if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_pct_in   = '0;
         rsp_cum_in   = acc_ff;
         rsp_done_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      x_ff        <= x_in;
      acc_ff      <= acc_in;
      step_ff     <= step_in;
      shift_ff    <= shift_in;
      run_ff      <= run_in;
      rsp_pct_ff  <= rsp_pct_in;
      rsp_cum_ff  <= rsp_cum_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_percentile_value = rsp_pct_ff;
   assign rsp_cumulative_count = rsp_cum_ff;
   assign rsp_compute_done     = rsp_done_ff;

   hcp_ram #(.WIDTH(COUNT_W), .DEPTH(NUM_BINS)) u_raw_ram (
      .clock   (clock),
      .wr_en   (raw_wr_en),
      .wr_addr (req_bin_index),
      .wr_data (req_bin_count),
      .rd_addr (idx_ff),
      .rd_data (raw_rdata)
   );

   hcp_ram #(.WIDTH(COUNT_W), .DEPTH(NUM_BINS)) u_cum_ram (
      .clock   (clock),
      .wr_en   (cum_wr_en),
      .wr_addr (idx_ff),
      .wr_data (cum_sum),
      .rd_addr (cum_rd_addr),
      .rd_data (cum_rdata)
   );

   hcp_ram #(.WIDTH(PCT_W), .DEPTH(NUM_BINS)) u_pct_ram (
      .clock   (clock),
      .wr_en   (pct_wr_en),
      .wr_addr (x_ff),
      .wr_data (idx_ff),
      .rd_addr (pct_rd_addr),
      .rd_data (pct_rdata)
   );

endmodule
